// ===== rtl/tgq_pkg.sv =====
// Shared types and constants for the team grouped queue.
// No dependencies; used by the top level.
package tgq_pkg;

  localparam int unsigned TEAM_IN_W   = 10;
  localparam int unsigned ID_IN_W     = 20;
  localparam int unsigned RECIP_SHIFT = 2 * TEAM_IN_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned TEAMS_W     = 17;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DEQ_OK   = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ENQ_OK   = 2'd2,
    ST_ENQ_FULL = 2'd3
  } status_e;

endpackage

// ===== rtl/team_grouped_queue.sv =====
// Team grouped queue: one FIFO in which an enqueued member is linked directly behind the
// last queued member of its team, or at the global tail when its team has nothing queued.
// Every request gives exactly one result. A new request is accepted only after the previous
// one has put its result on the output; a dequeue from an empty queue or an enqueue into a
// full pool is refused and goes straight to its result. Each request walks a chain of
// dependent reads through the node memory and the team table, and the node link memory
// has a single write port. After reset the team table is cleared, one entry per cycle,
// and no request is accepted until every entry is cleared.
// Depends on tgq_pkg, tgq_node_store and tgq_team_table.
module team_grouped_queue #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned TEAMS    = 1024,
  parameter int unsigned ID_WIDTH = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [tgq_pkg::ID_IN_W-1:0]    member_id_i,
  input  logic [tgq_pkg::TEAM_IN_W-1:0]  team_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tgq_pkg::ID_IN_W-1:0]    dequeued_id_o,
  output logic [1:0]                     status_o
);

  localparam int unsigned NW     = $clog2(CAPACITY);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned TW     = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int unsigned IN_W   = tgq_pkg::TEAM_IN_W;
  localparam int unsigned PROD_W = IN_W + tgq_pkg::RECIP_W;
  localparam int unsigned QT_W   = IN_W + tgq_pkg::TEAMS_W;
  localparam logic [tgq_pkg::RECIP_W-1:0] RECIP_L =
    tgq_pkg::RECIP_W'((64'd1 << tgq_pkg::RECIP_SHIFT) / TEAMS);
  localparam logic [tgq_pkg::TEAMS_W-1:0] TEAMS_L = tgq_pkg::TEAMS_W'(TEAMS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_E_ALLOC,
    S_E_FREE,
    S_E_PLACE,
    S_E_LINK,
    S_E_FIX,
    S_D_READ,
    S_D_POP,
    S_D_TEAM,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [NW-1:0]                head_q;
  logic [NW-1:0]                tail_q;
  logic [NW-1:0]                free_q;
  logic [CW-1:0]                occ_q;
  logic [CW-1:0]                fresh_q;
  logic [ID_WIDTH-1:0]          id_q;
  logic [IN_W-1:0]              team_q;
  logic [PROD_W-1:0]            prod_q;
  logic [TW-1:0]                tidx_q;
  logic [TW-1:0]                t_q;
  logic [NW-1:0]                n_q;
  logic [NW-1:0]                p_q;
  tgq_pkg::status_e             res_status_q;
  logic [tgq_pkg::ID_IN_W-1:0]  res_id_q;
  logic                         out_valid_q;
  tgq_pkg::status_e             out_status_q;
  logic [tgq_pkg::ID_IN_W-1:0]  out_id_q;

  logic                 tbl_ready;
  logic [NW-1:0]        node_raddr;
  logic [NW-1:0]        node_next_rd;
  logic [ID_WIDTH-1:0]  node_member_rd;
  logic [TW-1:0]        node_team_rd;
  logic                 next_we;
  logic [NW-1:0]        next_waddr;
  logic [NW-1:0]        next_wdata;
  logic                 pay_we;
  logic [TW-1:0]        team_raddr;
  logic                 team_rd_valid;
  logic [NW-1:0]        team_rd_ptr;
  logic                 team_we;
  logic [TW-1:0]        team_waddr;
  logic                 team_wvalid;
  logic [NW-1:0]        team_wptr;

  logic [IN_W-1:0]      quot;
  logic [QT_W-1:0]      qt_full;
  logic [IN_W:0]        rem;
  logic [IN_W:0]        rem_fix;
  logic [TW-1:0]        tidx_c;
  logic                 fresh_hit;
  logic [NW-1:0]        fresh_succ;
  logic                 in_accept;

  assign in_stall_o    = (state_q != S_IDLE) || !tbl_ready;
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign dequeued_id_o = out_id_q;
  assign status_o      = out_status_q;

  // Team number reduced modulo TEAMS by a reciprocal multiply and one correction.
  assign quot    = prod_q[tgq_pkg::RECIP_SHIFT +: IN_W];
  assign qt_full = QT_W'(quot) * QT_W'(TEAMS_L);
  assign rem     = {1'b0, team_q} - qt_full[IN_W:0];
  assign rem_fix = (tgq_pkg::TEAMS_W'(rem) >= TEAMS_L) ? rem - TEAMS_L[IN_W:0] : rem;
  assign tidx_c  = TW'(rem_fix);

  // Nodes at or above fresh_q have never been allocated; their free successor is the next index.
  assign fresh_hit  = (fresh_q != CW'(CAPACITY)) && (fresh_q[NW-1:0] == n_q);
  assign fresh_succ = (fresh_q == CW'(CAPACITY - 1)) ? '0 : fresh_q[NW-1:0] + 1'b1;

  tgq_node_store #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH),
    .TEAM_W   (TW)
  ) u_node_store (
    .clk_i        (clk_i),
    .raddr_i      (node_raddr),
    .next_o       (node_next_rd),
    .member_o     (node_member_rd),
    .team_o       (node_team_rd),
    .next_we_i    (next_we),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .pay_we_i     (pay_we),
    .pay_waddr_i  (n_q),
    .pay_member_i (id_q),
    .pay_team_i   (tidx_q)
  );

  tgq_team_table #(
    .TEAMS (TEAMS),
    .TW    (TW),
    .PTR_W (NW)
  ) u_team_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ready_o    (tbl_ready),
    .raddr_i    (team_raddr),
    .rd_valid_o (team_rd_valid),
    .rd_ptr_o   (team_rd_ptr),
    .we_i       (team_we),
    .waddr_i    (team_waddr),
    .wvalid_i   (team_wvalid),
    .wptr_i     (team_wptr)
  );

  always_comb begin
    node_raddr  = head_q;
    team_raddr  = tidx_q;
    next_we     = 1'b0;
    next_waddr  = n_q;
    next_wdata  = '0;
    pay_we      = 1'b0;
    team_we     = 1'b0;
    team_waddr  = tidx_q;
    team_wvalid = 1'b1;
    team_wptr   = n_q;
    case (state_q)
      S_E_ALLOC: begin
        node_raddr = free_q;
      end
      S_E_FREE: begin
        team_raddr = tidx_c;
      end
      S_E_PLACE: begin
        pay_we  = 1'b1;
        team_we = 1'b1;
        if ((occ_q != '0) && team_rd_valid) begin
          node_raddr = team_rd_ptr;
        end else begin
          next_we = 1'b1;
        end
      end
      S_E_LINK: begin
        next_we    = 1'b1;
        next_wdata = node_next_rd;
      end
      S_E_FIX: begin
        next_we    = 1'b1;
        next_waddr = p_q;
        next_wdata = n_q;
      end
      S_D_POP: begin
        team_raddr = node_team_rd;
        next_we    = 1'b1;
        next_wdata = free_q;
      end
      S_D_TEAM: begin
        team_we     = team_rd_valid && (team_rd_ptr == n_q);
        team_waddr  = t_q;
        team_wvalid = 1'b0;
        team_wptr   = team_rd_ptr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      free_q       <= '0;
      occ_q        <= '0;
      fresh_q      <= '0;
      id_q         <= '0;
      team_q       <= '0;
      prod_q       <= '0;
      tidx_q       <= '0;
      t_q          <= '0;
      n_q          <= '0;
      p_q          <= '0;
      res_status_q <= tgq_pkg::ST_EMPTY;
      res_id_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= tgq_pkg::ST_EMPTY;
      out_id_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            id_q     <= ID_WIDTH'(member_id_i);
            team_q   <= team_i;
            res_id_q <= '0;
            if (op_i == tgq_pkg::OP_DEQ) begin
              if (occ_q == '0) begin
                res_status_q <= tgq_pkg::ST_EMPTY;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_D_READ;
              end
            end else if (occ_q == CW'(CAPACITY)) begin
              res_status_q <= tgq_pkg::ST_ENQ_FULL;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_E_ALLOC;
            end
          end
        end
        S_E_ALLOC: begin
          prod_q  <= PROD_W'(team_q) * PROD_W'(RECIP_L);
          n_q     <= free_q;
          state_q <= S_E_FREE;
        end
        S_E_FREE: begin
          tidx_q <= tidx_c;
          if (fresh_hit) begin
            free_q  <= fresh_succ;
            fresh_q <= fresh_q + 1'b1;
          end else begin
            free_q <= node_next_rd;
          end
          state_q <= S_E_PLACE;
        end
        S_E_PLACE: begin
          occ_q        <= occ_q + 1'b1;
          res_status_q <= tgq_pkg::ST_ENQ_OK;
          if (occ_q == '0) begin
            head_q  <= n_q;
            tail_q  <= n_q;
            state_q <= S_DONE;
          end else if (team_rd_valid) begin
            p_q <= team_rd_ptr;
            if (team_rd_ptr == tail_q) begin
              tail_q <= n_q;
            end
            state_q <= S_E_LINK;
          end else begin
            p_q     <= tail_q;
            tail_q  <= n_q;
            state_q <= S_E_FIX;
          end
        end
        S_E_LINK: begin
          state_q <= S_E_FIX;
        end
        S_E_FIX: begin
          state_q <= S_DONE;
        end
        S_D_READ: begin
          n_q     <= head_q;
          state_q <= S_D_POP;
        end
        S_D_POP: begin
          res_status_q <= tgq_pkg::ST_DEQ_OK;
          res_id_q     <= tgq_pkg::ID_IN_W'(node_member_rd);
          head_q       <= node_next_rd;
          free_q       <= n_q;
          occ_q        <= occ_q - 1'b1;
          t_q          <= node_team_rd;
          if (occ_q == CW'(1)) begin
            tail_q <= '0;
          end
          state_q <= S_D_TEAM;
        end
        S_D_TEAM: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_id_q     <= res_id_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY))
    else $error("occupancy exceeds the node pool");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CW'(CAPACITY) && occ_q <= fresh_q)
    else $error("fresh node count out of range");

  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && occ_q == '0) |-> (tail_q == '0))
    else $error("empty queue keeps a nonzero tail");

  a_deq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D_READ) |-> (occ_q != '0))
    else $error("dequeue walk started on an empty queue");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tbl_ready |-> (state_q == S_IDLE && !out_valid_q))
    else $error("request in flight during the team table clearing pass");

endmodule

// ===== rtl/tgq_node_store.sv =====
// Node pool memories: the link to the next node and the member and team payload of each node.
// Synchronous read, with read data registered in the cycle after the address. No package dependencies.
module tgq_node_store #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ID_WIDTH = 20,
  parameter int unsigned TEAM_W   = 10
) (
  input  logic                        clk_i,
  input  logic [$clog2(CAPACITY)-1:0] raddr_i,
  output logic [$clog2(CAPACITY)-1:0] next_o,
  output logic [ID_WIDTH-1:0]         member_o,
  output logic [TEAM_W-1:0]           team_o,
  input  logic                        next_we_i,
  input  logic [$clog2(CAPACITY)-1:0] next_waddr_i,
  input  logic [$clog2(CAPACITY)-1:0] next_wdata_i,
  input  logic                        pay_we_i,
  input  logic [$clog2(CAPACITY)-1:0] pay_waddr_i,
  input  logic [ID_WIDTH-1:0]         pay_member_i,
  input  logic [TEAM_W-1:0]           pay_team_i
);

  localparam int unsigned NW = $clog2(CAPACITY);

  logic [NW-1:0]       next_mem   [CAPACITY];
  logic [ID_WIDTH-1:0] member_mem [CAPACITY];
  logic [TEAM_W-1:0]   team_mem   [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (next_we_i) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    next_o <= next_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we_i) begin
      member_mem[pay_waddr_i] <= pay_member_i;
      team_mem[pay_waddr_i]   <= pay_team_i;
    end
    member_o <= member_mem[raddr_i];
    team_o   <= team_mem[raddr_i];
  end

endmodule

// ===== rtl/tgq_team_table.sv =====
// Per-team tail table: a valid mark and the last queued node of each team.
// After reset a clearing pass zeroes every entry before ready_o rises. No package dependencies.
module tgq_team_table #(
  parameter int unsigned TEAMS = 1024,
  parameter int unsigned TW    = 10,
  parameter int unsigned PTR_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             ready_o,
  input  logic [TW-1:0]    raddr_i,
  output logic             rd_valid_o,
  output logic [PTR_W-1:0] rd_ptr_o,
  input  logic             we_i,
  input  logic [TW-1:0]    waddr_i,
  input  logic             wvalid_i,
  input  logic [PTR_W-1:0] wptr_i
);

  logic [PTR_W:0]  tbl_mem [TEAMS];
  logic            clr_busy_q;
  logic [TW-1:0]   clr_idx_q;
  logic            mem_we;
  logic [TW-1:0]   mem_waddr;
  logic [PTR_W:0]  mem_wdata;

  assign ready_o = !clr_busy_q;

  always_comb begin
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = we_i;
      mem_waddr = waddr_i;
      mem_wdata = {wvalid_i, wptr_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == TW'(TEAMS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    {rd_valid_o, rd_ptr_o} <= tbl_mem[raddr_i];
  end

endmodule

// ===== tb/sv/team_grouped_queue_tb.sv =====
// Testbench for team_grouped_queue. Directed cases, random request mixes, and a fill of the
// whole pool under a long output hold, each result checked against a queue model kept here.
// Depends on tgq_pkg and the team_grouped_queue RTL.
module team_grouped_queue_tb;

  localparam int unsigned CAPACITY     = 1024;
  localparam int unsigned TEAMS        = 1024;
  localparam int unsigned ID_W         = tgq_pkg::ID_IN_W;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned TEAM_W       = tgq_pkg::TEAM_IN_W;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MIX_ITEMS    = 64;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    tgq_pkg::status_e status;
  } queue_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              op_i        = tgq_pkg::OP_ENQ;
  logic [ID_W-1:0]   member_id_i = '0;
  logic [TEAM_W-1:0] team_i      = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [ID_W-1:0]   dequeued_id_o;
  logic [1:0]        status_o;

  logic [IDX_W-1:0]  link_next [CAPACITY];
  logic [ID_W-1:0]   slot_member [CAPACITY];
  logic [IDX_W-1:0]  slot_team [CAPACITY];
  logic [IDX_W-1:0]  team_last [TEAMS];
  bit                team_last_valid [TEAMS];
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W:0]    used_count;

  queue_result_t     pending_results[$];
  int unsigned       status_seen [4];
  int unsigned       error_count     = 0;
  int unsigned       cycle_count     = 0;
  int unsigned       send_idle_pct   = 0;
  int unsigned       stall_pct       = 0;
  int unsigned       hold_cycles_req = 0;
  int unsigned       stall_hold_left = 0;

  team_grouped_queue #(
    .CAPACITY(CAPACITY),
    .TEAMS   (TEAMS),
    .ID_WIDTH(ID_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .member_id_i  (member_id_i),
    .team_i       (team_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dequeued_id_o(dequeued_id_o),
    .status_o     (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic reset_team_queue_model();
    for (int i = 0; i < CAPACITY; i++) begin
      link_next[i]   = IDX_W'(i + 1);
      slot_member[i] = '0;
      slot_team[i]   = '0;
    end
    for (int i = 0; i < TEAMS; i++) begin
      team_last[i]       = '0;
      team_last_valid[i] = 1'b0;
    end
    head_idx   = '0;
    tail_idx   = '0;
    free_idx   = '0;
    used_count = '0;
  endtask

  function automatic queue_result_t predict_team_queue(tgq_pkg::op_e op, logic [ID_W-1:0] id,
                                                       logic [TEAM_W-1:0] team);
    queue_result_t    r;
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] p;
    r.id = '0;
    if (op == tgq_pkg::OP_DEQ) begin
      if (used_count == 0) begin
        r.status = tgq_pkg::ST_EMPTY;
      end else begin
        n        = head_idx;
        r.id     = slot_member[n];
        r.status = tgq_pkg::ST_DEQ_OK;
        if (team_last_valid[slot_team[n]] && team_last[slot_team[n]] == n) begin
          team_last_valid[slot_team[n]] = 1'b0;
        end
        head_idx     = link_next[n];
        link_next[n] = free_idx;
        free_idx     = n;
        used_count   = used_count - 1'b1;
        if (used_count == 0) begin
          tail_idx = '0;
        end
      end
    end else if (used_count == CAPACITY) begin
      r.status = tgq_pkg::ST_ENQ_FULL;
    end else begin
      n              = free_idx;
      free_idx       = link_next[n];
      slot_member[n] = id;
      slot_team[n]   = team;
      if (used_count == 0) begin
        head_idx     = n;
        tail_idx     = n;
        link_next[n] = '0;
      end else if (team_last_valid[team]) begin
        // Join behind the last queued member of the same team.
        p            = team_last[team];
        link_next[n] = link_next[p];
        link_next[p] = n;
        if (p == tail_idx) begin
          tail_idx = n;
        end
      end else begin
        link_next[tail_idx] = n;
        link_next[n]        = '0;
        tail_idx            = n;
      end
      team_last[team]       = n;
      team_last_valid[team] = 1'b1;
      used_count            = used_count + 1'b1;
      r.status              = tgq_pkg::ST_ENQ_OK;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      want = predict_team_queue(tgq_pkg::op_e'(op_i), member_id_i, team_i);
      pending_results.push_back(want);
      status_seen[want.status]++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, got id=%h status=%0d", $time,
                 dequeued_id_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (dequeued_id_o !== want.id) begin
          error_count++;
          $display("%0t: dequeued_id expected %h, got %h", $time, want.id, dequeued_id_o);
        end
        if (status_o !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles_req != 0) begin
      stall_hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (stall_hold_left != 0) begin
      out_stall_i <= 1'b1;
      stall_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("team_grouped_queue_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [TEAM_W-1:0] pick_team();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 7) return TEAM_W'($urandom_range(7));
    if (r < 9) return TEAM_W'($urandom);
    return $urandom_range(1) ? '1 : '0;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ID_W'($urandom);
  endfunction

  task automatic send_request(tgq_pkg::op_e op, logic [ID_W-1:0] id,
                              logic [TEAM_W-1:0] team);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    member_id_i <= id;
    team_i      <= team;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_request(tgq_pkg::OP_DEQ, '1, '1);
    send_request(tgq_pkg::OP_ENQ, '0, '0);
    send_request(tgq_pkg::OP_ENQ, '1, '1);
    send_request(tgq_pkg::OP_ENQ, 20'hAAAAA, '0);
    send_request(tgq_pkg::OP_ENQ, 20'h55555, '1);
    send_request(tgq_pkg::OP_ENQ, 20'h12345, 10'h155);
    send_request(tgq_pkg::OP_ENQ, 20'hEDCBA, 10'h2AA);
    repeat (7) send_request(tgq_pkg::OP_DEQ, '0, '0);
    send_request(tgq_pkg::OP_ENQ, 20'h0F0F0, '0);
    send_request(tgq_pkg::OP_ENQ, 20'hF0F0F, '0);
    send_request(tgq_pkg::OP_DEQ, 20'h33333, 10'h0CC);
    send_request(tgq_pkg::OP_ENQ, 20'hCCCCC, '0);
    send_request(tgq_pkg::OP_ENQ, 20'h00001, 10'h001);
    repeat (4) send_request(tgq_pkg::OP_DEQ, '1, '1);
    wait_all_results();
  endtask

  // The long output hold backs the block up until it stalls its input.
  task automatic test_fill_with_hold();
    int unsigned room;
    send_idle_pct   = 0;
    stall_pct       = 0;
    room            = CAPACITY - used_count;
    hold_cycles_req = 600;
    repeat (room) send_request(tgq_pkg::OP_ENQ, pick_id(), TEAM_W'($urandom_range(15)));
    repeat (3) send_request(tgq_pkg::OP_ENQ, pick_id(), pick_team());
    send_request(tgq_pkg::OP_DEQ, pick_id(), pick_team());
    send_request(tgq_pkg::OP_ENQ, pick_id(), pick_team());
    send_request(tgq_pkg::OP_ENQ, pick_id(), pick_team());
    repeat (8) send_request(tgq_pkg::OP_DEQ, pick_id(), pick_team());
    wait_all_results();
  endtask

  task automatic test_random_mix(int unsigned idle_pct, int unsigned stall_mix_pct,
                                 int unsigned count);
    int unsigned enq_pct;
    send_idle_pct = idle_pct;
    stall_pct     = stall_mix_pct;
    for (int i = 0; i < count; i++) begin
      enq_pct = (i < count / 2) ? 90 : 70;
      if ($urandom_range(99) < enq_pct) begin
        send_request(tgq_pkg::OP_ENQ, pick_id(), pick_team());
      end else begin
        send_request(tgq_pkg::OP_DEQ, pick_id(), pick_team());
      end
    end
    wait_all_results();
  endtask

  initial begin
    reset_team_queue_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_mix(0, 0, MIX_ITEMS);
    test_random_mix(75, 0, MIX_ITEMS);
    test_random_mix(0, 75, MIX_ITEMS);
    test_random_mix(8, 8, MIX_ITEMS);
    test_fill_with_hold();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Checked %0d enqueues, %0d refused on a full pool, %0d dequeues, %0d on empty.",
             status_seen[tgq_pkg::ST_ENQ_OK], status_seen[tgq_pkg::ST_ENQ_FULL],
             status_seen[tgq_pkg::ST_DEQ_OK], status_seen[tgq_pkg::ST_EMPTY]);
    $display("Runs covered directed cases, four idle mixes and a full pool under output hold.");
    if (error_count == 0) begin
      $display("team_grouped_queue_tb OK");
    end else begin
      $display("team_grouped_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
